### rtl/ddo_pkg.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_pkg: shared types and constants of the odometry integrator
// Holds the fixed formats, register indexes, the controller-to-datapath
// command word and the CORDIC arctangent table.
// ----------------------------------------------------------------------------
package ddo_pkg;

    localparam int CFG_INDEX_WIDTH = 8;
    localparam int CFG_DATA_WIDTH  = 32;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_DIST_PER_COUNT = 8'd0;
    localparam logic [CFG_INDEX_WIDTH-1:0] REG_TURN_PER_COUNT = 8'd1;

    localparam logic [31:0] DIST_PER_COUNT_RESET = 32'd13422;
    localparam logic [31:0] TURN_PER_COUNT_RESET = 32'd1093664;

    localparam int POS_WIDTH     = 48;
    localparam int HEADING_WIDTH = 32;
    localparam int ANGLE_WIDTH   = 32;

    // CORDIC vectors in Q1.30 and residual angle in binary-angle units, with headroom.
    localparam int CORDIC_STEPS = 24;
    localparam int ITER_WIDTH   = 5;
    localparam int CORDIC_WIDTH = 34;
    localparam logic signed [CORDIC_WIDTH-1:0] CORDIC_GAIN = 34'sh0_26DD_3B6A;

    // Shared multiplier: 33-bit operand A by 32-bit operand B.
    localparam int MUL_A_WIDTH = 33;
    localparam int MUL_B_WIDTH = 32;
    localparam int PROD_WIDTH  = MUL_A_WIDTH + MUL_B_WIDTH;

    localparam int DMAG_WIDTH = 63;
    localparam int INC_WIDTH  = 63;
    localparam logic [INC_WIDTH-1:0] INC_CAP = 63'h4000_0000_0000_0000;

    localparam int SUM_WIDTH = 64;
    localparam logic signed [SUM_WIDTH-1:0] POS_MAX = 64'sh0000_7FFF_FFFF_FFFF;
    localparam logic signed [SUM_WIDTH-1:0] POS_MIN = -64'sh0000_8000_0000_0000;

    typedef enum logic [2:0] {
        MUL_NONE,
        MUL_DIST,
        MUL_TURN,
        MUL_X_LO,
        MUL_X_HI,
        MUL_Y_LO,
        MUL_Y_HI
    } mul_op_t;

    typedef struct packed {
        logic                  start;
        logic                  cordic_step;
        logic [ITER_WIDTH-1:0] iter;
        mul_op_t               mul_op;
        logic                  latch_trig;
        logic                  commit;
    } ddo_cmd_t;

    function automatic logic [ANGLE_WIDTH-1:0] atan_turn(input logic [ITER_WIDTH-1:0] idx);
        logic [ANGLE_WIDTH-1:0] val;
        case (idx)
            5'd0:    val = 32'h2000_0000;
            5'd1:    val = 32'h12E4_051E;
            5'd2:    val = 32'h09FB_385B;
            5'd3:    val = 32'h0511_11D4;
            5'd4:    val = 32'h028B_0D43;
            5'd5:    val = 32'h0145_D7E1;
            5'd6:    val = 32'h00A2_F61E;
            5'd7:    val = 32'h0051_7C55;
            5'd8:    val = 32'h0028_BE53;
            5'd9:    val = 32'h0014_5F2F;
            5'd10:   val = 32'h000A_2F98;
            5'd11:   val = 32'h0005_17CC;
            5'd12:   val = 32'h0002_8BE6;
            5'd13:   val = 32'h0001_45F3;
            5'd14:   val = 32'h0000_A2FA;
            5'd15:   val = 32'h0000_517D;
            5'd16:   val = 32'h0000_28BE;
            5'd17:   val = 32'h0000_145F;
            5'd18:   val = 32'h0000_0A30;
            5'd19:   val = 32'h0000_0518;
            5'd20:   val = 32'h0000_028C;
            5'd21:   val = 32'h0000_0146;
            5'd22:   val = 32'h0000_00A3;
            5'd23:   val = 32'h0000_0051;
            default: val = 32'h0000_0000;
        endcase
        return val;
    endfunction

endpackage
`default_nettype wire

### rtl/diff_drive_odometry_integrator_core.sv
`default_nettype none
// ----------------------------------------------------------------------------
// diff_drive_odometry_integrator_core: two-wheel dead-reckoning integrator
// Integrates encoder count changes into a saturating x/y position and a
// wrapping binary-angle heading.
// ----------------------------------------------------------------------------
// Each accepted item (left and right count changes) advances the pose by one
// step and yields one pose transfer. An item first runs the 24-iteration
// CORDIC that produces cosine and sine of the old heading, followed by four
// passes through the single shared 33x32 multiplier for the two 63-bit
// position increments, and is then committed; no new item is taken until
// the controller is back in idle. The input may be taken while the previous
// pose still waits on the output; that pose stays stable until it is
// transferred, and the new one is committed afterwards. Configuration writes
// are meant for idle periods only.
module diff_drive_odometry_integrator_core #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                                  clk,
    input  wire logic                                  rst_n,
    input  wire logic                                  cfg_write,
    input  wire logic [ddo_pkg::CFG_INDEX_WIDTH-1:0]   cfg_index,
    input  wire logic [ddo_pkg::CFG_DATA_WIDTH-1:0]    cfg_data,
    input  wire logic                                  item_valid,
    output      logic                                  item_stall,
    input  wire logic signed [COUNT_WIDTH-1:0]         left_count,
    input  wire logic signed [COUNT_WIDTH-1:0]         right_count,
    output      logic                                  pose_valid,
    input  wire logic                                  pose_stall,
    output      logic signed [ddo_pkg::POS_WIDTH-1:0]  pose_x,
    output      logic signed [ddo_pkg::POS_WIDTH-1:0]  pose_y,
    output      logic [ddo_pkg::HEADING_WIDTH-1:0]     pose_heading
);
    import ddo_pkg::*;

    ddo_cmd_t cmd;

    ddo_ctrl u_ctrl (
        .clk        (clk),
        .rst_n      (rst_n),
        .item_valid (item_valid),
        .item_stall (item_stall),
        .pose_valid (pose_valid),
        .pose_stall (pose_stall),
        .cmd        (cmd)
    );

    ddo_datapath #(
        .COUNT_WIDTH (COUNT_WIDTH)
    ) u_datapath (
        .clk          (clk),
        .rst_n        (rst_n),
        .cmd          (cmd),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .left_count   (left_count),
        .right_count  (right_count),
        .pose_x       (pose_x),
        .pose_y       (pose_y),
        .pose_heading (pose_heading)
    );

endmodule
`default_nettype wire

### rtl/ddo_ctrl.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_ctrl: sequencer of the odometry integrator
// Steps the datapath through the CORDIC iterations, the multiplier schedule
// and the final commit, and owns both handshakes.
// ----------------------------------------------------------------------------
module ddo_ctrl (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              item_valid,
    output      logic              item_stall,
    output      logic              pose_valid,
    input  wire logic              pose_stall,
    output      ddo_pkg::ddo_cmd_t cmd
);
    import ddo_pkg::*;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_CORDIC,
        ST_TRIG,
        ST_MUL_XL,
        ST_MUL_XH,
        ST_MUL_YL,
        ST_MUL_YH,
        ST_DRAIN,
        ST_COMMIT
    } state_t;

    localparam logic [ITER_WIDTH-1:0] LAST_ITER = ITER_WIDTH'(CORDIC_STEPS - 1);

    state_t                state_reg;
    logic [ITER_WIDTH-1:0] iter_reg;
    logic                  pose_valid_reg;
    logic                  out_free;

    assign item_stall = (state_reg != ST_IDLE);
    assign pose_valid = pose_valid_reg;
    // The pose registers may only move once the previous result has been taken.
    assign out_free   = !pose_valid_reg || !pose_stall;

    always_comb
    begin
        cmd             = '0;
        cmd.mul_op      = MUL_NONE;
        cmd.iter        = iter_reg;
        case (state_reg)
            ST_IDLE:   cmd.start = item_valid;
            ST_CORDIC:
            begin
                cmd.cordic_step = 1'b1;
                // The distance and turn products run alongside the rotation.
                if (iter_reg == '0)
                begin
                    cmd.mul_op = MUL_DIST;
                end
                else if (iter_reg == ITER_WIDTH'(1))
                begin
                    cmd.mul_op = MUL_TURN;
                end
            end
            ST_TRIG:   cmd.latch_trig = 1'b1;
            ST_MUL_XL: cmd.mul_op = MUL_X_LO;
            ST_MUL_XH: cmd.mul_op = MUL_X_HI;
            ST_MUL_YL: cmd.mul_op = MUL_Y_LO;
            ST_MUL_YH: cmd.mul_op = MUL_Y_HI;
            ST_DRAIN:  cmd.mul_op = MUL_NONE;
            ST_COMMIT: cmd.commit = out_free;
            default:   cmd.mul_op = MUL_NONE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            iter_reg       <= '0;
            pose_valid_reg <= 1'b0;
        end
        else
        begin
            if (cmd.commit)
            begin
                pose_valid_reg <= 1'b1;
            end
            else if (pose_valid_reg && !pose_stall)
            begin
                pose_valid_reg <= 1'b0;
            end
            case (state_reg)
                ST_IDLE:
                begin
                    iter_reg <= '0;
                    if (item_valid)
                    begin
                        state_reg <= ST_CORDIC;
                    end
                end
                ST_CORDIC:
                begin
                    iter_reg <= iter_reg + ITER_WIDTH'(1);
                    if (iter_reg == LAST_ITER)
                    begin
                        state_reg <= ST_TRIG;
                    end
                end
                ST_TRIG:   state_reg <= ST_MUL_XL;
                ST_MUL_XL: state_reg <= ST_MUL_XH;
                ST_MUL_XH: state_reg <= ST_MUL_YL;
                ST_MUL_YL: state_reg <= ST_MUL_YH;
                ST_MUL_YH: state_reg <= ST_DRAIN;
                ST_DRAIN:  state_reg <= ST_COMMIT;
                ST_COMMIT:
                begin
                    if (out_free)
                    begin
                        state_reg <= ST_IDLE;
                    end
                end
                default:   state_reg <= ST_IDLE;
            endcase
        end
    end

endmodule
`default_nettype wire

### rtl/ddo_datapath.sv
`default_nettype none
// ----------------------------------------------------------------------------
// ddo_datapath: arithmetic of the odometry integrator
// Configuration registers, the iterative CORDIC, one shared multiplier with
// tagged write-back, and the saturating pose accumulators.
// ----------------------------------------------------------------------------
module ddo_datapath #(
    parameter int COUNT_WIDTH = 16
) (
    input  wire logic                                      clk,
    input  wire logic                                      rst_n,
    input  wire ddo_pkg::ddo_cmd_t                         cmd,
    input  wire logic                                      cfg_write,
    input  wire logic [ddo_pkg::CFG_INDEX_WIDTH-1:0]       cfg_index,
    input  wire logic [ddo_pkg::CFG_DATA_WIDTH-1:0]        cfg_data,
    input  wire logic signed [COUNT_WIDTH-1:0]             left_count,
    input  wire logic signed [COUNT_WIDTH-1:0]             right_count,
    output      logic signed [ddo_pkg::POS_WIDTH-1:0]      pose_x,
    output      logic signed [ddo_pkg::POS_WIDTH-1:0]      pose_y,
    output      logic [ddo_pkg::HEADING_WIDTH-1:0]         pose_heading
);
    import ddo_pkg::*;

    localparam int CMSB = CORDIC_WIDTH - 1;

    function automatic logic signed [POS_WIDTH-1:0] sat_add(
        input logic signed [POS_WIDTH-1:0] acc,
        input logic                        neg,
        input logic [INC_WIDTH-1:0]        mag
    );
        logic signed [SUM_WIDTH-1:0] acc_w;
        logic signed [SUM_WIDTH-1:0] mag_w;
        logic signed [SUM_WIDTH-1:0] sum_w;
        acc_w = SUM_WIDTH'(acc);
        mag_w = signed'({1'b0, mag});
        sum_w = neg ? (acc_w - mag_w) : (acc_w + mag_w);
        if (sum_w > POS_MAX)
        begin
            sum_w = POS_MAX;
        end
        else if (sum_w < POS_MIN)
        begin
            sum_w = POS_MIN;
        end
        return POS_WIDTH'(sum_w);
    endfunction

    // Configuration
    logic [31:0] dpc_reg;
    logic [31:0] tpc_reg;

    // Per-item operands
    logic                    sum_neg_reg;
    logic [COUNT_WIDTH:0]    sum_mag_reg;
    logic [31:0]             diff_reg;
    logic signed [COUNT_WIDTH:0] left_ext;
    logic signed [COUNT_WIDTH:0] right_ext;
    logic signed [COUNT_WIDTH:0] sum_cw;
    logic signed [COUNT_WIDTH:0] diff_cw;
    logic signed [MUL_A_WIDTH-1:0] diff_wide;

    // CORDIC
    logic signed [CORDIC_WIDTH-1:0] cx_reg;
    logic signed [CORDIC_WIDTH-1:0] cy_reg;
    logic signed [CORDIC_WIDTH-1:0] cz_reg;
    logic                           flip_reg;
    logic                           flip;
    logic [ANGLE_WIDTH-1:0]         angle;
    logic signed [CORDIC_WIDTH-1:0] dx;
    logic signed [CORDIC_WIDTH-1:0] dy;
    logic signed [CORDIC_WIDTH-1:0] step_angle;
    logic [CORDIC_WIDTH-1:0]        cx_abs;
    logic [CORDIC_WIDTH-1:0]        cy_abs;

    // Trig magnitudes and signs
    logic [MUL_B_WIDTH-1:0] cmag_reg;
    logic [MUL_B_WIDTH-1:0] smag_reg;
    logic                   cneg_reg;
    logic                   sneg_reg;

    // Shared multiplier
    logic [MUL_A_WIDTH-1:0] mul_a;
    logic [MUL_B_WIDTH-1:0] mul_b;
    logic [PROD_WIDTH-1:0]  prod_reg;
    mul_op_t                tag_reg;

    // Results of the multiplier schedule
    logic [DMAG_WIDTH-1:0]    dmag_reg;
    logic [HEADING_WIDTH-1:0] dth_reg;
    logic [63:0]              lo_reg;
    logic [INC_WIDTH-1:0]     inc_x_reg;
    logic [INC_WIDTH-1:0]     inc_y_reg;
    logic [PROD_WIDTH-1:0]    dist_round;
    logic [INC_WIDTH-1:0]     inc_sum;
    logic [INC_WIDTH-1:0]     inc_capped;

    // Accumulators
    logic signed [POS_WIDTH-1:0] x_acc_reg;
    logic signed [POS_WIDTH-1:0] y_acc_reg;
    logic [HEADING_WIDTH-1:0]    heading_reg;

    assign pose_x       = x_acc_reg;
    assign pose_y       = y_acc_reg;
    assign pose_heading = heading_reg;

    assign left_ext  = {left_count[COUNT_WIDTH-1], left_count};
    assign right_ext = {right_count[COUNT_WIDTH-1], right_count};
    assign sum_cw    = left_ext + right_ext;
    assign diff_cw   = right_ext - left_ext;
    assign diff_wide = MUL_A_WIDTH'(diff_cw);

    // Headings in the left half-plane are rotated by half a turn first.
    assign flip  = heading_reg[31] ^ heading_reg[30];
    assign angle = flip ? (heading_reg + 32'h8000_0000) : heading_reg;

    assign dx         = cy_reg >>> cmd.iter;
    assign dy         = cx_reg >>> cmd.iter;
    assign step_angle = signed'(CORDIC_WIDTH'(atan_turn(cmd.iter)));
    assign cx_abs     = cx_reg[CMSB] ? CORDIC_WIDTH'(-cx_reg) : CORDIC_WIDTH'(cx_reg);
    assign cy_abs     = cy_reg[CMSB] ? CORDIC_WIDTH'(-cy_reg) : CORDIC_WIDTH'(cy_reg);

    always_comb
    begin
        case (cmd.mul_op)
            MUL_DIST:
            begin
                mul_a = MUL_A_WIDTH'(sum_mag_reg);
                mul_b = dpc_reg;
            end
            MUL_TURN:
            begin
                mul_a = MUL_A_WIDTH'(diff_reg);
                mul_b = tpc_reg;
            end
            MUL_X_LO:
            begin
                mul_a = MUL_A_WIDTH'(dmag_reg[31:0]);
                mul_b = cmag_reg;
            end
            MUL_X_HI:
            begin
                mul_a = MUL_A_WIDTH'(dmag_reg[DMAG_WIDTH-1:32]);
                mul_b = cmag_reg;
            end
            MUL_Y_LO:
            begin
                mul_a = MUL_A_WIDTH'(dmag_reg[31:0]);
                mul_b = smag_reg;
            end
            MUL_Y_HI:
            begin
                mul_a = MUL_A_WIDTH'(dmag_reg[DMAG_WIDTH-1:32]);
                mul_b = smag_reg;
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
    end

    // A negative distance is halved rounding toward minus infinity.
    assign dist_round = {1'b0, prod_reg[63:0]} + PROD_WIDTH'(sum_neg_reg);

    // Increment = hi * 4 + lo / 2^30, capped at 2^62.
    assign inc_sum = INC_WIDTH'({prod_reg[59:0], 2'b00}) + INC_WIDTH'(lo_reg[63:30]);
    assign inc_capped = ((prod_reg[PROD_WIDTH-1:60] != '0) || (inc_sum > INC_CAP))
                        ? INC_CAP : inc_sum;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dpc_reg     <= DIST_PER_COUNT_RESET;
            tpc_reg     <= TURN_PER_COUNT_RESET;
            tag_reg     <= MUL_NONE;
            x_acc_reg   <= '0;
            y_acc_reg   <= '0;
            heading_reg <= '0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == REG_DIST_PER_COUNT)
                begin
                    dpc_reg <= cfg_data;
                end
                else if (cfg_index == REG_TURN_PER_COUNT)
                begin
                    tpc_reg <= cfg_data;
                end
            end
            tag_reg <= cmd.mul_op;
            if (cmd.commit)
            begin
                x_acc_reg   <= sat_add(x_acc_reg, sum_neg_reg != cneg_reg, inc_x_reg);
                y_acc_reg   <= sat_add(y_acc_reg, sum_neg_reg == sneg_reg, inc_y_reg);
                heading_reg <= heading_reg + dth_reg;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        prod_reg <= PROD_WIDTH'(mul_a) * PROD_WIDTH'(mul_b);

        if (cmd.start)
        begin
            sum_neg_reg <= sum_cw[COUNT_WIDTH];
            sum_mag_reg <= sum_cw[COUNT_WIDTH] ? (COUNT_WIDTH + 1)'(-sum_cw)
                                               : (COUNT_WIDTH + 1)'(sum_cw);
            diff_reg    <= diff_wide[31:0];
            flip_reg    <= flip;
            cx_reg      <= CORDIC_GAIN;
            cy_reg      <= '0;
            cz_reg      <= CORDIC_WIDTH'(signed'(angle));
        end
        else if (cmd.cordic_step)
        begin
            if (!cz_reg[CMSB])
            begin
                cx_reg <= cx_reg - dx;
                cy_reg <= cy_reg + dy;
                cz_reg <= cz_reg - step_angle;
            end
            else
            begin
                cx_reg <= cx_reg + dx;
                cy_reg <= cy_reg - dy;
                cz_reg <= cz_reg + step_angle;
            end
        end

        if (cmd.latch_trig)
        begin
            cmag_reg <= cx_abs[MUL_B_WIDTH-1:0];
            smag_reg <= cy_abs[MUL_B_WIDTH-1:0];
            // The half-turn flip negates both results.
            cneg_reg <= flip_reg ? (!cx_reg[CMSB] && (cx_reg != '0)) : cx_reg[CMSB];
            sneg_reg <= flip_reg ? (!cy_reg[CMSB] && (cy_reg != '0)) : cy_reg[CMSB];
        end

        case (tag_reg)
            MUL_DIST: dmag_reg  <= dist_round[DMAG_WIDTH:1];
            MUL_TURN: dth_reg   <= prod_reg[HEADING_WIDTH-1:0];
            MUL_X_LO: lo_reg    <= prod_reg[63:0];
            MUL_X_HI: inc_x_reg <= inc_capped;
            MUL_Y_LO: lo_reg    <= prod_reg[63:0];
            MUL_Y_HI: inc_y_reg <= inc_capped;
            default:  lo_reg    <= lo_reg;
        endcase
    end

endmodule
`default_nettype wire

### bench/ddo_pose_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ddo_pose_checker: pose predictor and scoreboard for the odometry integrator
// Watches the register port and both channels, integrates every accepted
// encoder item into an expected pose and compares each pose transfer, field
// by field, against the oldest expected pose.
// ----------------------------------------------------------------------------
module ddo_pose_checker (
    input  wire logic                                 clk,
    input  wire logic                                 rst_n,
    input  wire logic                                 cfg_write,
    input  wire logic [ddo_pkg::CFG_INDEX_WIDTH-1:0]  cfg_index,
    input  wire logic [ddo_pkg::CFG_DATA_WIDTH-1:0]   cfg_data,
    input  wire logic                                 item_valid,
    input  wire logic                                 item_stall,
    input  wire logic signed [15:0]                   left_count,
    input  wire logic signed [15:0]                   right_count,
    input  wire logic                                 pose_valid,
    input  wire logic                                 pose_stall,
    input  wire logic signed [ddo_pkg::POS_WIDTH-1:0] pose_x,
    input  wire logic signed [ddo_pkg::POS_WIDTH-1:0] pose_y,
    input  wire logic [ddo_pkg::HEADING_WIDTH-1:0]    pose_heading,
    output int                                        fail_count,
    output int                                        poses_outstanding,
    output int                                        poses_checked,
    output int                                        limit_hits
);

    localparam int          TRIG_STEPS = 24;
    localparam longint      TRIG_GAIN  = 64'h0000_0000_26DD_3B6A;
    localparam logic [63:0] INC_LIMIT  = 64'h4000_0000_0000_0000;
    localparam longint      POS_HI     = 64'sh0000_7FFF_FFFF_FFFF;
    localparam longint      POS_LO     = -64'sh0000_8000_0000_0000;

    typedef struct {
        logic signed [47:0] x;
        logic signed [47:0] y;
        logic [31:0]        heading;
    } pose_t;

    logic [31:0] atan_steps [TRIG_STEPS];

    // Predictor state and its copy of the two registers.
    longint      pos_x    = 0;
    longint      pos_y    = 0;
    logic [31:0] heading  = '0;
    logic [31:0] reg_dist = ddo_pkg::DIST_PER_COUNT_RESET;
    logic [31:0] reg_turn = ddo_pkg::TURN_PER_COUNT_RESET;

    pose_t expected_poses [$];
    int    n_fail    = 0;
    int    n_checked = 0;
    int    n_limit   = 0;

    initial begin
        atan_steps = '{
            32'h2000_0000, 32'h12E4_051E, 32'h09FB_385B, 32'h0511_11D4,
            32'h028B_0D43, 32'h0145_D7E1, 32'h00A2_F61E, 32'h0051_7C55,
            32'h0028_BE53, 32'h0014_5F2F, 32'h000A_2F98, 32'h0005_17CC,
            32'h0002_8BE6, 32'h0001_45F3, 32'h0000_A2FA, 32'h0000_517D,
            32'h0000_28BE, 32'h0000_145F, 32'h0000_0A30, 32'h0000_0518,
            32'h0000_028C, 32'h0000_0146, 32'h0000_00A3, 32'h0000_0051
        };
    end

    // Cosine and sine of a binary angle in Q1.30. Angles in the left half
    // plane are turned by half a turn first and the results negated.
    function automatic void heading_trig(input logic [31:0] ang,
                                         output longint cosv, output longint sinv);
        logic        flip;
        logic [31:0] folded;
        longint      z;
        longint      vx;
        longint      vy;
        longint      dx;
        longint      dy;
        int          i;
        flip   = ang[31] ^ ang[30];
        folded = flip ? ang + 32'h8000_0000 : ang;
        z      = $signed(folded);
        vx     = TRIG_GAIN;
        vy     = 0;
        for (i = 0; i < TRIG_STEPS; i++)
        begin
            dx = vy >>> i;
            dy = vx >>> i;
            if (z >= 0)
            begin
                vx = vx - dx;
                vy = vy + dy;
                z  = z - longint'(atan_steps[i]);
            end
            else
            begin
                vx = vx + dx;
                vy = vy - dy;
                z  = z + longint'(atan_steps[i]);
            end
        end
        cosv = flip ? -vx : vx;
        sinv = flip ? -vy : vy;
    endfunction

    function automatic logic [63:0] scale_q30(input logic [63:0] mag, input logic [63:0] frac);
        logic [127:0] full;
        full = (128'(mag) * 128'(frac)) >> 30;
        return (full > 128'(INC_LIMIT)) ? INC_LIMIT : full[63:0];
    endfunction

    function automatic longint add_saturated(input longint acc, input logic neg,
                                             input logic [63:0] mag);
        longint v;
        v = neg ? acc - longint'(mag) : acc + longint'(mag);
        if (v > POS_HI)
            return POS_HI;
        if (v < POS_LO)
            return POS_LO;
        return v;
    endfunction

    // Advances the predicted pose by one encoder item and returns the new pose.
    function automatic pose_t integrate_step(input logic signed [15:0] l,
                                             input logic signed [15:0] r);
        longint      sum;
        longint      cs;
        longint      sn;
        logic        dneg;
        logic        cneg;
        logic        sneg;
        logic [63:0] prod;
        logic [63:0] dist_mag;
        logic [31:0] diff;
        logic [31:0] dtheta;
        pose_t       p;
        sum      = longint'(l) + longint'(r);
        dneg     = sum < 0;
        prod     = 64'(dneg ? -sum : sum) * 64'(reg_dist);
        // Halving rounds toward minus infinity, so a negative odd product
        // grows by one in magnitude.
        dist_mag = dneg ? (prod + 64'd1) >> 1 : prod >> 1;
        diff     = $signed(r) - $signed(l);
        dtheta   = diff * reg_turn;
        heading_trig(heading, cs, sn);
        cneg  = cs < 0;
        sneg  = sn < 0;
        pos_x = add_saturated(pos_x, dneg != cneg, scale_q30(dist_mag, cneg ? -cs : cs));
        pos_y = add_saturated(pos_y, dneg == sneg, scale_q30(dist_mag, sneg ? -sn : sn));
        heading = heading + dtheta;
        if (pos_x == POS_HI || pos_x == POS_LO || pos_y == POS_HI || pos_y == POS_LO)
            n_limit++;
        p.x       = pos_x[47:0];
        p.y       = pos_y[47:0];
        p.heading = heading;
        return p;
    endfunction

    always @(posedge clk or negedge rst_n)
    begin : monitor
        pose_t want;
        if (!rst_n)
        begin
            pos_x    = 0;
            pos_y    = 0;
            heading  = '0;
            reg_dist = ddo_pkg::DIST_PER_COUNT_RESET;
            reg_turn = ddo_pkg::TURN_PER_COUNT_RESET;
            expected_poses.delete();
            poses_outstanding <= 0;
        end
        else
        begin
            if (cfg_write)
            begin
                if (cfg_index == ddo_pkg::REG_DIST_PER_COUNT)
                    reg_dist = cfg_data;
                else if (cfg_index == ddo_pkg::REG_TURN_PER_COUNT)
                    reg_turn = cfg_data;
            end

            if (pose_valid && !pose_stall)
            begin
                if (expected_poses.size() == 0)
                begin
                    $error("pose transfer with no pose expected: x %0d, y %0d, heading %0h",
                           pose_x, pose_y, pose_heading);
                    n_fail++;
                end
                else
                begin
                    want = expected_poses.pop_front();
                    if (pose_x !== want.x)
                    begin
                        $error("pose_x: expected %0d, actual %0d", want.x, pose_x);
                        n_fail++;
                    end
                    if (pose_y !== want.y)
                    begin
                        $error("pose_y: expected %0d, actual %0d", want.y, pose_y);
                        n_fail++;
                    end
                    if (pose_heading !== want.heading)
                    begin
                        $error("pose_heading: expected %0h, actual %0h",
                               want.heading, pose_heading);
                        n_fail++;
                    end
                    n_checked++;
                end
            end

            if (item_valid && !item_stall)
                expected_poses.push_back(integrate_step(left_count, right_count));

            // The counts the stimulus side polls change only after the edge.
            fail_count        <= n_fail;
            poses_outstanding <= expected_poses.size();
            poses_checked     <= n_checked;
            limit_hits        <= n_limit;
        end
    end

endmodule

### bench/tb_diff_drive_odometry_integrator_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_diff_drive_odometry_integrator_core: testbench of the odometry integrator
// Drives encoder items in random bursts under several register settings,
// stalls the pose output on a pattern of its own and leaves checking to
// ddo_pose_checker, which predicts every pose.
// ----------------------------------------------------------------------------
module tb_diff_drive_odometry_integrator_core;

    import ddo_pkg::*;

    localparam logic [CFG_INDEX_WIDTH-1:0] REG_UNMAPPED = 8'hA5;
    localparam int SEGMENT_ITEMS = 140;
    localparam int SEGMENTS      = 5;
    localparam int HOLD_AT       = 200;
    localparam int HOLD_CYCLES   = 400;
    localparam int SETTLE_CYCLES = 40;

    logic                        clk         = 1'b0;
    logic                        rst_n       = 1'b0;
    logic                        cfg_write   = 1'b0;
    logic [CFG_INDEX_WIDTH-1:0]  cfg_index   = '0;
    logic [CFG_DATA_WIDTH-1:0]   cfg_data    = '0;
    logic                        item_valid  = 1'b0;
    logic signed [15:0]          left_count  = '0;
    logic signed [15:0]          right_count = '0;
    logic                        pose_stall  = 1'b0;
    wire logic                   item_stall;
    wire logic                   pose_valid;
    wire logic signed [POS_WIDTH-1:0]  pose_x;
    wire logic signed [POS_WIDTH-1:0]  pose_y;
    wire logic [HEADING_WIDTH-1:0]     pose_heading;

    int fail_count;
    int poses_outstanding;
    int poses_checked;
    int limit_hits;
    int items_sent    = 0;
    int burst_left    = 0;
    int settings_used = 1;

    diff_drive_odometry_integrator_core u_dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .cfg_write    (cfg_write),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .left_count   (left_count),
        .right_count  (right_count),
        .pose_valid   (pose_valid),
        .pose_stall   (pose_stall),
        .pose_x       (pose_x),
        .pose_y       (pose_y),
        .pose_heading (pose_heading)
    );

    ddo_pose_checker u_checker (
        .clk               (clk),
        .rst_n             (rst_n),
        .cfg_write         (cfg_write),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .left_count        (left_count),
        .right_count       (right_count),
        .pose_valid        (pose_valid),
        .pose_stall        (pose_stall),
        .pose_x            (pose_x),
        .pose_y            (pose_y),
        .pose_heading      (pose_heading),
        .fail_count        (fail_count),
        .poses_outstanding (poses_outstanding),
        .poses_checked     (poses_checked),
        .limit_hits        (limit_hits)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    // Offers one item and returns at the edge of its transfer. Valid stays
    // high into the next item unless a gap opens a new burst.
    task automatic send_item(input logic signed [15:0] l, input logic signed [15:0] r);
        int gap;
        if (burst_left == 0)
        begin
            burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(20, 40)
                                                     : $urandom_range(1, 10);
            gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 20);
            if (gap > 0)
            begin
                item_valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
        end
        burst_left--;
        item_valid  <= 1'b1;
        left_count  <= l;
        right_count <= r;
        @(posedge clk);
        while (item_stall)
            @(posedge clk);
        items_sent++;
    endtask

    task automatic wait_idle();
        item_valid <= 1'b0;
        burst_left = 0;
        do
            @(posedge clk);
        while (poses_outstanding != 0);
    endtask

    // Writes both registers and an unmapped index, which the block ignores.
    task automatic program_regs(input logic [31:0] travel, input logic [31:0] turn);
        wait_idle();
        cfg_write <= 1'b1;
        cfg_index <= REG_DIST_PER_COUNT;
        cfg_data  <= travel;
        @(posedge clk);
        cfg_index <= REG_TURN_PER_COUNT;
        cfg_data  <= turn;
        @(posedge clk);
        cfg_index <= REG_UNMAPPED;
        cfg_data  <= $urandom;
        @(posedge clk);
        cfg_write <= 1'b0;
        @(posedge clk);
        settings_used++;
    endtask

    // Mostly near-straight driving with small counts, plus full-range values,
    // extremes and spins in place.
    task automatic random_item();
        logic signed [15:0] l;
        logic signed [15:0] r;
        int                 base;
        case ($urandom_range(0, 9))
            0, 1, 2, 3, 4, 5:
            begin
                base = $urandom_range(0, 1200) - 600;
                l    = 16'(base + $urandom_range(0, 40) - 20);
                r    = 16'(base + $urandom_range(0, 40) - 20);
            end
            6, 7:
            begin
                l = 16'($urandom);
                r = 16'($urandom);
            end
            8:
            begin
                l = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
                r = $urandom_range(0, 1) ? 16'sh7FFF : 16'sh8000;
            end
            default:
            begin
                l = 16'($urandom);
                r = -l;
            end
        endcase
        send_item(l, r);
    endtask

    // Output side: segments of free flow, random stalls, periodic stalls and
    // long blocks, with one long hold-off that backs the block up.
    initial
    begin : pose_receiver
        int  mode;
        int  run;
        int  k;
        bit  held;
        held = 1'b0;
        wait (rst_n);
        forever
        begin
            if (!held && items_sent >= HOLD_AT)
            begin
                held = 1'b1;
                pose_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(posedge clk);
            end
            mode = $urandom_range(0, 3);
            run  = $urandom_range(10, 80);
            for (k = 0; k < run; k++)
            begin
                case (mode)
                    0:       pose_stall <= 1'b0;
                    1:       pose_stall <= ($urandom_range(0, 1) == 1);
                    2:       pose_stall <= ((k % 4) == 3);
                    default: pose_stall <= (k < run / 2);
                endcase
                @(posedge clk);
            end
        end
    end

    initial
    begin : stimulus
        int seg;
        int n;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Reset register values: zero, extremes, rounding of negative odd sums.
        send_item(16'sh0000, 16'sh0000);
        send_item(16'sh7FFF, 16'sh7FFF);
        send_item(16'sh8000, 16'sh8000);
        send_item(16'sh7FFF, 16'sh8000);
        send_item(16'sh8000, 16'sh7FFF);
        send_item(16'sh0001, -16'sh0001);
        send_item(16'sh0001, 16'sh0000);
        send_item(16'sh0000, 16'sh0001);
        send_item(-16'sh0001, 16'sh0000);
        send_item(-16'sh0001, -16'sh0001);

        // Largest travel per count and a quarter turn per count: drive x to
        // both limits, turn, then y to both limits.
        program_regs(32'hFFFF_FFFF, 32'h4000_0000);
        repeat (2) send_item(16'sh7FFF, 16'sh7FFF);
        repeat (3) send_item(16'sh8000, 16'sh8000);
        send_item(16'sh0000, 16'sh0001);
        repeat (2) send_item(16'sh7FFF, 16'sh7FFF);
        repeat (3) send_item(16'sh8000, 16'sh8000);

        program_regs(32'h0000_0000, 32'h0000_0000);
        send_item(16'sh7FFF, 16'sh8000);
        send_item(16'sh8000, 16'sh7FFF);

        for (seg = 0; seg < SEGMENTS; seg++)
        begin
            case (seg)
                0: program_regs(DIST_PER_COUNT_RESET, TURN_PER_COUNT_RESET);
                1: program_regs($urandom_range(1, 65535), $urandom);
                2: program_regs($urandom, $urandom);
                3: program_regs(32'h0000_0000, 32'hFFFF_FFFF);
                default: program_regs($urandom_range(0, 1 << 20), $urandom_range(0, 1 << 24));
            endcase
            for (n = 0; n < SEGMENT_ITEMS; n++)
                random_item();
        end

        wait_idle();
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Checked %0d poses over %0d register settings;", poses_checked, settings_used);
        $display("%0d steps ended at a position limit.", limit_hits);
        if (fail_count == 0 && poses_outstanding == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("Simulation FAILED");
        $finish;
    end

endmodule

### files.f
rtl/ddo_pkg.sv
rtl/ddo_ctrl.sv
rtl/ddo_datapath.sv
rtl/diff_drive_odometry_integrator_core.sv
bench/ddo_pose_checker.sv
bench/tb_diff_drive_odometry_integrator_core.sv
